// ===== design/bss_pkg.sv =====
package bss_pkg;

    localparam int NUM_SIGS    = 8;
    localparam int SIG_MAX     = 37;
    localparam int SIG_ID_W    = 3;
    localparam int SIG_LEN_W   = 6;
    localparam int MATCH_OFF_W = 20;

    // Signature lengths in bytes, in priority order
    localparam logic [SIG_LEN_W-1:0] SIG_LEN [NUM_SIGS] = '{
        6'd31, 6'd37, 6'd37, 6'd36, 6'd36, 6'd31, 6'd13, 6'd14
    };

    // Signature bytes, first byte in the top byte lane, zero padded at the end
    localparam logic [SIG_MAX*8-1:0] SIG_BYTES [NUM_SIGS] = '{
        // strlen
        {8'h55, 8'h8b, 8'hec, 8'h57, 8'hc4, 8'h7e, 8'h06, 8'h33, 8'hc0, 8'h3b,
         8'h46, 8'h08, 8'h75, 8'h04, 8'h3b, 8'hc7, 8'h74, 8'h0a, 8'hfc, 8'hb9,
         8'hff, 8'hff, 8'hf2, 8'hae, 8'h91, 8'hf7, 8'hd0, 8'h48, 8'h5f, 8'h5d,
         8'hcb, {6{8'h00}}},
        // bioskey v2.0
        {8'h55, 8'h8b, 8'hec, 8'h32, 8'hc0, 8'h8a, 8'h66, 8'h06, 8'hcd, 8'h16,
         8'h74, 8'h0f, 8'hf6, 8'h46, 8'h06, 8'h01, 8'h75, 8'h11, 8'h0b, 8'hc0,
         8'h75, 8'h0d, 8'hb8, 8'hff, 8'hff, 8'heb, 8'h08, 8'hf6, 8'h46, 8'h06,
         8'h01, 8'h74, 8'h02, 8'h33, 8'hc0, 8'h5d, 8'hcb},
        // bioskey v3.1
        {8'h55, 8'h8b, 8'hec, 8'h32, 8'hc0, 8'h8a, 8'h66, 8'h06, 8'hcd, 8'h16,
         8'h74, 8'h0f, 8'hf6, 8'h46, 8'h06, 8'h01, 8'h74, 8'h11, 8'h0b, 8'hc0,
         8'h75, 8'h0d, 8'hb8, 8'hff, 8'hff, 8'heb, 8'h08, 8'hf6, 8'h46, 8'h06,
         8'h01, 8'h74, 8'h02, 8'h33, 8'hc0, 8'h5d, 8'hcb},
        // memcpy
        {8'h55, 8'h8b, 8'hec, 8'h56, 8'h57, 8'h8c, 8'hda, 8'hc4, 8'h7e, 8'h06,
         8'hc5, 8'h76, 8'h0a, 8'h8b, 8'h4e, 8'h0e, 8'hd1, 8'he9, 8'hfc, 8'hf3,
         8'ha5, 8'h73, 8'h01, 8'ha4, 8'h8e, 8'hda, 8'h8b, 8'h56, 8'h08, 8'h8b,
         8'h46, 8'h06, 8'h5f, 8'h5e, 8'h5d, 8'hcb, 8'h00},
        // setmem
        {8'h55, 8'h8b, 8'hec, 8'h57, 8'hc4, 8'h7e, 8'h06, 8'h8b, 8'h4e, 8'h0a,
         8'h8a, 8'h46, 8'h0c, 8'h8a, 8'he0, 8'hfc, 8'hf7, 8'hc7, 8'h01, 8'h00,
         8'h74, 8'h04, 8'he3, 8'h09, 8'haa, 8'h49, 8'hd1, 8'he9, 8'hf3, 8'hab,
         8'h73, 8'h01, 8'haa, 8'h5f, 8'h5d, 8'hcb, 8'h00},
        // memset
        {8'h55, 8'h8b, 8'hec, 8'h8a, 8'h46, 8'h0a, 8'h50, 8'hff, 8'h76, 8'h0c,
         8'hff, 8'h76, 8'h08, 8'hff, 8'h76, 8'h06, 8'h0e, 8'he8, 8'hc8, 8'hff,
         8'h83, 8'hc4, 8'h08, 8'h8b, 8'h56, 8'h08, 8'h8b, 8'h46, 8'h06, 8'h5d,
         8'hcb, {6{8'h00}}},
        // rotl
        {8'h55, 8'h8b, 8'hec, 8'h8b, 8'h46, 8'h06, 8'h8b, 8'h4e, 8'h08, 8'hd3,
         8'hc0, 8'h5d, 8'hcb, {24{8'h00}}},
        // abs
        {8'h55, 8'h8b, 8'hec, 8'h8b, 8'h46, 8'h06, 8'h0b, 8'hc0, 8'h7d, 8'h02,
         8'hf7, 8'hd8, 8'h5d, 8'hcb, {23{8'h00}}}
    };

    // One input request as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       may_start;
        logic       first;
    } scan_in_t;

    // Priority-resolved signature compare
    typedef struct packed {
        logic                any;
        logic [SIG_ID_W-1:0] id;
    } sig_match_t;

    // Result of one scan step
    typedef struct packed {
        logic                   hit;
        logic [SIG_ID_W-1:0]    pattern_id;
        logic [MATCH_OFF_W-1:0] match_offset;
    } scan_res_t;

endpackage

// ===== design/bss_matcher.sv =====
module bss_matcher (
    input  logic [bss_pkg::SIG_MAX-1:0][7:0] win,
    output bss_pkg::sig_match_t              result
);
    import bss_pkg::*;

    logic [NUM_SIGS-1:0] sig_hit;

    // Compare every signature against the window in parallel
    always_comb
    begin
        sig_hit = '1;
        for (int k = 0; k < NUM_SIGS; k++)
        begin
            for (int j = 0; j < SIG_MAX; j++)
            begin
                if ((SIG_LEN_W'(j) < SIG_LEN[k]) &&
                    (win[j] != SIG_BYTES[k][(SIG_MAX-1-j)*8 +: 8]))
                begin
                    sig_hit[k] = 1'b0;
                end
            end
        end
    end

    // Lowest-numbered hit wins
    always_comb
    begin
        result.any = |sig_hit;
        result.id  = '0;
        for (int k = NUM_SIGS - 1; k >= 0; k--)
        begin
            if (sig_hit[k])
            begin
                result.id = SIG_ID_W'(k);
            end
        end
    end

endmodule

// ===== design/bss_scan_core.sv =====
module bss_scan_core #(
    parameter int WINDOW_LEN  = 37,
    parameter int OFFSET_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  bss_pkg::scan_in_t req,
    output bss_pkg::scan_res_t res
);
    import bss_pkg::*;

    localparam logic [OFFSET_BITS-1:0] BACK_OFF = OFFSET_BITS'(WINDOW_LEN - 1);
    localparam logic [OFFSET_BITS-1:0] WIN_SPAN = OFFSET_BITS'(WINDOW_LEN);

    // Window, index 0 is the oldest byte
    logic [WINDOW_LEN-1:0][7:0] win_reg;
    logic [WINDOW_LEN-1:0][7:0] win_next;
    logic [WINDOW_LEN-1:0]      ok_reg;
    logic [WINDOW_LEN-1:0]      ok_next;
    logic [OFFSET_BITS-1:0]     pos_reg;
    logic [OFFSET_BITS-1:0]     pos_next;
    logic [OFFSET_BITS-1:0]     supp_reg;
    logic [OFFSET_BITS-1:0]     supp_next;

    logic [OFFSET_BITS-1:0]     pos_eff;
    logic [OFFSET_BITS-1:0]     supp_eff;
    logic [OFFSET_BITS-1:0]     oldest;
    logic [OFFSET_BITS-1:0]     remain;
    logic                       suppressed;
    sig_match_t                 sig;

    // Shift in the new byte; a new scan drops all earlier start flags
    always_comb
    begin
        win_next = {req.data_byte, win_reg[WINDOW_LEN-1:1]};
        if (req.first)
        begin
            ok_next = {req.may_start, {(WINDOW_LEN-1){1'b0}}};
        end
        else
        begin
            ok_next = {req.may_start, ok_reg[WINDOW_LEN-1:1]};
        end
    end

    // Offset of the oldest byte and the suppression window test
    always_comb
    begin
        pos_eff    = req.first ? '0 : pos_reg;
        supp_eff   = req.first ? '0 : supp_reg;
        oldest     = pos_eff - BACK_OFF;
        remain     = supp_eff - oldest;
        suppressed = (remain != '0) && (remain <= WIN_SPAN);
        pos_next   = pos_eff + OFFSET_BITS'(1);
    end

    bss_matcher u_matcher (
        .win    (win_next[SIG_MAX-1:0]),
        .result (sig)
    );

    // Accept a start at the oldest byte
    always_comb
    begin
        res.hit          = ok_next[0] && !suppressed && sig.any;
        res.pattern_id   = sig.id;
        res.match_offset = MATCH_OFF_W'(oldest);
        if (res.hit)
        begin
            supp_next = oldest + OFFSET_BITS'(SIG_LEN[sig.id]);
        end
        else
        begin
            supp_next = supp_eff;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg   <= '0;
            pos_reg  <= '0;
            supp_reg <= '0;
        end
        else if (step)
        begin
            ok_reg   <= ok_next;
            pos_reg  <= pos_next;
            supp_reg <= supp_next;
        end
    end

    // Window bytes; unfilled slots carry no start flag so need no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            win_reg <= win_next;
        end
    end

endmodule

// ===== design/byte_signature_scanner_top.sv =====
// A byte completing the window is taken into the input register, and a match
// from it is then taken into the result register that drives match_valid; a
// stalled earlier match can hold the byte in the input register in between.
// Throughput: one byte per clock while byte_stall is low; the suppression
// update loop through the signature compare and offset add is combinational.
// Reset: rst_n clears the start flags, offsets and both valid registers; a
// request after reset is handled as if it had first set.
module byte_signature_scanner_top #(
    parameter int WINDOW_LEN  = 37,
    parameter int OFFSET_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                may_start,
    input  logic                                first,
    output logic                                match_valid,
    input  logic                                match_stall,
    output logic [bss_pkg::SIG_ID_W-1:0]        pattern_id,
    output logic [bss_pkg::MATCH_OFF_W-1:0]     match_offset
);
    import bss_pkg::*;

    scan_in_t  s1_req_reg;
    logic      s1_valid_reg;
    scan_res_t core_res;
    logic      advance;

    logic                   match_valid_reg;
    logic [SIG_ID_W-1:0]    pattern_id_reg;
    logic [MATCH_OFF_W-1:0] match_offset_reg;

    // Process the held request unless its match would overwrite a stalled result
    assign advance    = s1_valid_reg &&
                        (!core_res.hit || !match_valid_reg || !match_stall);
    assign byte_stall = s1_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            s1_req_reg <= '{data_byte: data_byte, may_start: may_start, first: first};
        end
    end

    bss_scan_core #(
        .WINDOW_LEN  (WINDOW_LEN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (s1_req_reg),
        .res   (core_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_valid_reg <= 1'b0;
        end
        else if (advance && core_res.hit)
        begin
            match_valid_reg <= 1'b1;
        end
        else if (!match_stall)
        begin
            match_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_res.hit)
        begin
            pattern_id_reg   <= core_res.pattern_id;
            match_offset_reg <= core_res.match_offset;
        end
    end

    assign match_valid  = match_valid_reg;
    assign pattern_id   = pattern_id_reg;
    assign match_offset = match_offset_reg;

endmodule
